FILE: src/ordered_byte_list_engine_top_defines.svh
// ---------------------------------------------------------------------------
// Ordered byte list engine: assertion macros
// Shared check forms for the ordered byte list engine.
// ---------------------------------------------------------------------------
`ifndef ORDERED_BYTE_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_BYTE_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define OLBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define OLBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/olbe_pkg.sv
// ---------------------------------------------------------------------------
// Ordered byte list engine package
// Types, codes and constants shared by the list cells and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olbe_pkg;

  localparam int OLBE_CAPACITY = 64;
  localparam int OP_W          = 3;
  localparam int POS_W         = 7;
  localparam int ITEM_W        = 8;
  localparam int LEN_W         = 7;
  localparam int FPOS_W        = 6;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_REMOVE_LAST  = 3'd1,
    OP_READ         = 3'd2,
    OP_PREPEND      = 3'd3,
    OP_INSERT       = 3'd4,
    OP_REMOVE_FIRST = 3'd5,
    OP_REMOVE_AT    = 3'd6,
    OP_FIND         = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;    // open a slot at the position, store item
    logic              del;    // close the slot at the position
    logic              pick;   // cell at the position drives its byte on the tap bus
    logic              start;  // load the search token into cell 0
    logic              step;   // move the search token one cell up
    logic [ITEM_W-1:0] item;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: src/ordered_byte_list_engine_top.sv
// Ordered byte list engine. Keeps up to CAPACITY bytes in a chain of cells,
// one byte per cell, and answers one request per transaction with one result.
// Append, prepend, insert, the three removes and read finish in the cycle
// the request is accepted, so these run one per cycle as long as results are
// taken. Find walks a token up the chain one cell per cycle, stopping at the
// first match or at the last held byte; no new request is taken during
// that walk. List contents are not cleared at reset: only positions below the
// current length are ever read.
// ---------------------------------------------------------------------------
// Ordered byte list engine top level
// Request decode, chain of list cells, find sequencer and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_byte_list_engine_top_defines.svh"

module ordered_byte_list_engine_top
  import olbe_pkg::*;
#(
  parameter int CAPACITY = OLBE_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // operation[2:0], position[9:3], item[17:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // value[7:0], length[14:8], found[15],
                                       // found_position[21:16], status[23:22]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  // request fields
  op_t               in_op;
  logic [POS_W-1:0]  in_pos;
  logic [ITEM_W-1:0] in_item;
  logic              in_acc;

  assign in_op   = op_t'(in_tdata[2:0]);
  assign in_pos  = in_tdata[9:3];
  assign in_item = in_tdata[17:10];

  // control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [ITEM_W-1:0] item_r, item_nxt;

  // result register
  logic              out_tvalid_r;
  logic [ITEM_W-1:0] out_value_r;
  logic [LEN_W-1:0]  out_length_r;
  logic              out_found_r;
  logic [FPOS_W-1:0] out_fpos_r;
  status_t           out_status_r;

  logic              load;
  logic [ITEM_W-1:0] res_value;
  logic              res_found;
  logic [IW-1:0]     res_fpos;
  status_t           res_status;

  // chain
  cell_cmd_t         cmd;
  logic [WW-1:0]     cmd_pos;
  logic [ITEM_W-1:0] data_w [CAPACITY];
  logic [ITEM_W-1:0] tap_w  [CAPACITY];
  logic [CAPACITY-1:0] tok_w, match_w;
  logic [ITEM_W-1:0] tap_or;
  logic              match_any;

  logic [WW-1:0]     pos_w, cnt_w;
  logic              empty, full, scan_last;

  assign pos_w     = WW'(in_pos);
  assign cnt_w     = WW'(count_r);
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(CAPACITY));
  assign scan_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign match_any = |match_w;

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [ITEM_W-1:0] left_d, right_d;
    logic              tok_l;

    if (gi == 0) begin : g_first
      assign left_d = cmd.item;
      assign tok_l  = 1'b0;
    end else begin : g_mid
      assign left_d = data_w[gi-1];
      assign tok_l  = tok_w[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign right_d = data_w[gi];
    end else begin : g_inner
      assign right_d = data_w[gi+1];
    end

    olbe_cell #(
      .INDEX (gi),
      .PW    (WW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .cmd_pos    (cmd_pos),
      .data_left  (left_d),
      .data_right (right_d),
      .tok_left   (tok_l),
      .data       (data_w[gi]),
      .tok        (tok_w[gi]),
      .tap        (tap_w[gi]),
      .match      (match_w[gi])
    );
  end

  // at most one cell drives the tap bus
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | tap_w[i];
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.item   = in_item;
    cmd_pos    = '0;
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    item_nxt   = item_r;
    load       = 1'b0;
    res_value  = '0;
    res_found  = 1'b0;
    res_fpos   = '0;
    res_status = STAT_OK;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load = 1'b1;
          case (in_op)
            OP_APPEND: begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                cmd.ins   = 1'b1;
                cmd_pos   = cnt_w;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE_LAST: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                cmd.del   = 1'b1;
                cmd.pick  = 1'b1;
                cmd_pos   = cnt_w - WW'(1);
                res_value = tap_or;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_READ: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else if (pos_w >= cnt_w) begin
                res_status = STAT_RANGE;
              end else begin
                cmd.pick  = 1'b1;
                cmd_pos   = pos_w;
                res_value = tap_or;
              end
            end
            OP_PREPEND: begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                cmd.ins   = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INSERT: begin
              if (pos_w > cnt_w) begin
                res_status = STAT_RANGE;
              end else if (full) begin
                res_status = STAT_FULL;
              end else begin
                cmd.ins   = 1'b1;
                cmd_pos   = pos_w;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE_FIRST: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                cmd.del   = 1'b1;
                cmd.pick  = 1'b1;
                res_value = tap_or;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_REMOVE_AT: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else if (pos_w >= cnt_w) begin
                res_status = STAT_RANGE;
              end else begin
                cmd.del   = 1'b1;
                cmd.pick  = 1'b1;
                cmd_pos   = pos_w;
                res_value = tap_or;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_FIND: begin
              // empty list answers not found at once
              if (!empty) begin
                load      = 1'b0;
                cmd.start = 1'b1;
                idx_nxt   = '0;
                item_nxt  = in_item;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // output register is empty here: it was free when the find was taken
        cmd.item = item_r;
        if (match_any || scan_last) begin
          load      = 1'b1;
          res_found = match_any;
          res_fpos  = match_any ? idx_r : '0;
          state_nxt = S_IDLE;
        end else begin
          cmd.step = 1'b1;
          idx_nxt  = idx_r + IW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (load) begin
      out_value_r  <= res_value;
      out_length_r <= LEN_W'(count_nxt);
      out_found_r  <= res_found;
      out_fpos_r   <= FPOS_W'(res_fpos);
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_status_r, out_fpos_r, out_found_r, out_length_r, out_value_r};

  `OLBE_ASSERT_NOW(a_scan_out_empty, state_r == S_SCAN, !out_tvalid_r,
                   "result register busy during find walk")
  `OLBE_ASSERT_NOW(a_scan_one_token, state_r == S_SCAN, $onehot(tok_w),
                   "find walk lost or duplicated its token")
  `OLBE_ASSERT_NOW(a_idle_no_token, state_r == S_IDLE, tok_w == '0,
                   "token left in chain while idle")
  `OLBE_ASSERT_NEXT(a_count_bound, 1'b1, count_r <= CW'(CAPACITY),
                    "list length above capacity")

endmodule

`default_nettype wire

FILE: src/olbe_cell.sv
// ---------------------------------------------------------------------------
// Ordered byte list cell
// Holds one list byte; shifts to or from its neighbors on insert and remove,
// and carries the search token along the chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olbe_cell
  import olbe_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int PW    = POS_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_cmd_t         cmd,
  input  wire logic [PW-1:0]     cmd_pos,
  input  wire logic [ITEM_W-1:0] data_left,
  input  wire logic [ITEM_W-1:0] data_right,
  input  wire logic              tok_left,
  output logic [ITEM_W-1:0]      data,
  output logic                   tok,
  output logic [ITEM_W-1:0]      tap,
  output logic                   match
);

  localparam logic [PW-1:0] MY_POS = PW'(INDEX);

  logic [ITEM_W-1:0] data_r, data_nxt;
  logic              tok_r, tok_nxt;
  logic              below, at;

  assign below = (MY_POS < cmd_pos);
  assign at    = (MY_POS == cmd_pos);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (at) begin
        data_nxt = cmd.item;
      end else if (!below) begin
        data_nxt = data_left;
      end
    end else if (cmd.del) begin
      if (!below) begin
        data_nxt = data_right;
      end
    end
  end

  always_comb begin
    if (cmd.start) begin
      tok_nxt = (INDEX == 0);
    end else if (cmd.step) begin
      tok_nxt = tok_left;
    end else begin
      tok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign data  = data_r;
  assign tok   = tok_r;
  assign tap   = (cmd.pick && at) ? data_r : '0;
  assign match = tok_r && (data_r == cmd.item);

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// Ordered byte list engine testbench
// A directed table walks the empty, range and full corners of the list. Then
// segmented random traffic grows, drains and searches it. A queue model of
// the list checks every result in order while both stream sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import olbe_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RAND_ITEMS  = 1600;
  localparam int TAIL_CYCLES = 80;       // longer than a full-length find walk
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  // Declared MSB first so the struct lines up with out_tdata bit for bit
  typedef struct packed {
    status_t           status;
    logic [FPOS_W-1:0] fpos;
    logic              found;
    logic [LEN_W-1:0]  length;
    logic [ITEM_W-1:0] value;
  } list_result_t;

  typedef struct {
    op_t          op;
    int           pos;
    int           item;
    int           reps;
    bit           typed;
    list_result_t res;
  } dir_row_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_LOOKUP} mix_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // operation[2:0], position[9:3], item[17:10]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // value[7:0], length[14:8], found[15],
                            // found_position[21:16], status[23:22]

  logic [ITEM_W-1:0] held_bytes[$];
  list_result_t      pending_results[$];
  dir_row_t          dir_tab[$];

  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;
  int cycle_cnt    = 0;
  int sent_cnt     = 0;
  int checked_cnt  = 0;
  int mismatch_cnt = 0;
  int full_cnt     = 0;
  int empty_cnt    = 0;
  int range_cnt    = 0;
  int found_cnt    = 0;

  ordered_byte_list_engine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // List model: applies one request to held_bytes and returns its result
  function automatic list_result_t apply_request(op_t op, logic [POS_W-1:0] pos,
                                                 logic [ITEM_W-1:0] item);
    list_result_t r;
    int n;
    int p;
    r = '0;
    r.status = STAT_OK;
    n = held_bytes.size();
    p = int'(pos);
    case (op)
      OP_APPEND: begin
        if (n >= OLBE_CAPACITY) r.status = STAT_FULL;
        else held_bytes.push_back(item);
      end
      OP_REMOVE_LAST: begin
        if (n == 0) r.status = STAT_EMPTY;
        else r.value = held_bytes.pop_back();
      end
      OP_READ: begin
        if (n == 0) r.status = STAT_EMPTY;
        else if (p >= n) r.status = STAT_RANGE;
        else r.value = held_bytes[p];
      end
      OP_PREPEND: begin
        if (n >= OLBE_CAPACITY) r.status = STAT_FULL;
        else held_bytes.push_front(item);
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (p > n) r.status = STAT_RANGE;
        else if (n >= OLBE_CAPACITY) r.status = STAT_FULL;
        else held_bytes.insert(p, item);
      end
      OP_REMOVE_FIRST: begin
        if (n == 0) r.status = STAT_EMPTY;
        else r.value = held_bytes.pop_front();
      end
      OP_REMOVE_AT: begin
        if (n == 0) r.status = STAT_EMPTY;
        else if (p >= n) r.status = STAT_RANGE;
        else begin
          r.value = held_bytes[p];
          held_bytes.delete(p);
        end
      end
      default: begin
        for (int i = 0; i < n && !r.found; i++) begin
          if (held_bytes[i] == item) begin
            r.found = 1'b1;
            r.fpos  = FPOS_W'(i);
          end
        end
      end
    endcase
    r.length = LEN_W'(held_bytes.size());
    return r;
  endfunction

  function automatic void add_row(op_t op, int pos, int item, int reps = 1);
    dir_row_t row;
    row.op    = op;
    row.pos   = pos;
    row.item  = item;
    row.reps  = reps;
    row.typed = 1'b0;
    row.res   = '0;
    dir_tab.push_back(row);
  endfunction

  // Row whose result is known outright: value, found and position all zero
  function automatic void add_exp(op_t op, int pos, int item, int len, status_t st);
    dir_row_t row;
    row.op         = op;
    row.pos        = pos;
    row.item       = item;
    row.reps       = 1;
    row.typed      = 1'b1;
    row.res        = '0;
    row.res.length = LEN_W'(len);
    row.res.status = st;
    dir_tab.push_back(row);
  endfunction

  function automatic op_t pick_op(mix_t mix);
    int w;
    int k;
    w = $urandom_range(0, 99);
    k = $urandom_range(0, 2);
    if (w < 70) begin
      case (mix)
        MIX_GROW:   return (k == 0) ? OP_APPEND : (k == 1) ? OP_PREPEND : OP_INSERT;
        MIX_SHRINK: return (k == 0) ? OP_REMOVE_LAST :
                           (k == 1) ? OP_REMOVE_FIRST : OP_REMOVE_AT;
        MIX_LOOKUP: return (k == 0) ? OP_READ : OP_FIND;
        default: ;
      endcase
    end
    return op_t'($urandom_range(0, 7));
  endfunction

  // Holds the request until the transaction completes, then books its result
  task automatic send_req(op_t op, logic [POS_W-1:0] pos, logic [ITEM_W-1:0] item,
                          bit typed, list_result_t want);
    int gap;
    list_result_t pred;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, item, pos, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_request(op, pos, item);
    case (pred.status)
      STAT_FULL:  full_cnt++;
      STAT_EMPTY: empty_cnt++;
      STAT_RANGE: range_cnt++;
      default: ;
    endcase
    if (pred.found) found_cnt++;
    pending_results.push_back(typed ? want : pred);
    sent_cnt++;
  endtask

  // Request side: directed table, then random segments
  initial begin
    mix_t mix;
    int seg_len;
    int done;
    int n;
    op_t op;
    logic [POS_W-1:0] pos;
    logic [ITEM_W-1:0] item;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;

    add_exp(OP_REMOVE_LAST, 0, 8'h00, 0, STAT_EMPTY);
    add_exp(OP_READ, 0, 8'h00, 0, STAT_EMPTY);
    add_exp(OP_REMOVE_FIRST, 0, 8'h00, 0, STAT_EMPTY);
    add_exp(OP_REMOVE_AT, 127, 8'hFF, 0, STAT_EMPTY);
    add_exp(OP_FIND, 0, 8'h00, 0, STAT_OK);             // find on empty list
    add_exp(OP_INSERT, 1, 8'hFF, 0, STAT_RANGE);        // insert past end
    add_exp(OP_INSERT, 0, 8'hFF, 1, STAT_OK);
    add_exp(OP_APPEND, 0, 8'h00, 2, STAT_OK);
    add_exp(OP_PREPEND, 127, 8'h80, 3, STAT_OK);
    add_row(OP_READ, 2, 8'h00);
    add_exp(OP_READ, 3, 8'h00, 3, STAT_RANGE);
    add_exp(OP_READ, 127, 8'h00, 3, STAT_RANGE);
    add_row(OP_FIND, 0, 8'hFF);
    add_exp(OP_FIND, 0, 8'hAA, 3, STAT_OK);             // byte not held
    add_row(OP_INSERT, 3, 8'h01);                       // insert at length appends
    add_exp(OP_REMOVE_AT, 4, 8'h00, 4, STAT_RANGE);
    add_row(OP_REMOVE_AT, 1, 8'h00);
    add_row(OP_APPEND, 0, 8'h5A, OLBE_CAPACITY - 3);    // fill to capacity
    add_exp(OP_APPEND, 0, 8'h00, OLBE_CAPACITY, STAT_FULL);
    add_exp(OP_PREPEND, 0, 8'h00, OLBE_CAPACITY, STAT_FULL);
    add_exp(OP_INSERT, OLBE_CAPACITY, 8'h00, OLBE_CAPACITY, STAT_FULL);
    add_exp(OP_INSERT, OLBE_CAPACITY + 1, 8'h00, OLBE_CAPACITY, STAT_RANGE);
    add_row(OP_FIND, 0, 8'h01);
    add_exp(OP_FIND, 0, 8'hAA, OLBE_CAPACITY, STAT_OK); // walks the whole chain
    add_row(OP_READ, OLBE_CAPACITY - 1, 8'h00);
    add_row(OP_REMOVE_LAST, 0, 8'h00);
    add_row(OP_REMOVE_FIRST, 0, 8'h00, OLBE_CAPACITY - 1);
    add_exp(OP_REMOVE_FIRST, 0, 8'h00, 0, STAT_EMPTY);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].reps)
        send_req(dir_tab[i].op, POS_W'(dir_tab[i].pos), ITEM_W'(dir_tab[i].item),
                 dir_tab[i].typed, dir_tab[i].res);
    end

    done = 0;
    while (done < RAND_ITEMS) begin
      mix      = mix_t'($urandom_range(0, 3));
      seg_len  = $urandom_range(20, 120);
      in_quiet = ($urandom_range(0, 4) == 0);
      repeat (seg_len) begin
        n = held_bytes.size();
        if ($urandom_range(0, 9) == 0) begin
          op   = op_t'($urandom_range(0, 7));
          pos  = POS_W'($urandom_range(0, 127));
          item = ITEM_W'($urandom_range(0, 255));
        end else begin
          op   = pick_op(mix);
          item = ITEM_W'($urandom_range(0, 255));
          if (op == OP_INSERT) pos = POS_W'($urandom_range(0, n));
          else pos = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
          // mostly search for a byte that is held
          if (op == OP_FIND && n > 0 && $urandom_range(0, 2) != 0)
            item = held_bytes[$urandom_range(0, n - 1)];
        end
        send_req(op, pos, item, 1'b0, '0);
        done++;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d mismatches",
             sent_cnt, checked_cnt, mismatch_cnt);
    $display("refusals seen: full %0d, empty %0d, out of range %0d; finds located %0d",
             full_cnt, empty_cnt, range_cnt, found_cnt);
    if (mismatch_cnt == 0) begin
      $display("ordered_byte_list_engine_top regression: pass");
    end else begin
      $display("ordered_byte_list_engine_top regression: fail");
    end
    $finish;
  end

  // Result side back-pressure
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 59) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = list_result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%t: result with nothing pending: tdata %h", $realtime, out_tdata);
      end else begin
        want = pending_results.pop_front();
        checked_cnt++;
        if (got.value !== want.value || got.length !== want.length ||
            got.found !== want.found || got.fpos !== want.fpos ||
            got.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%t: result %0d exp val %h len %0d fnd %b pos %0d st %0d",
                     $realtime, checked_cnt,
                     want.value, want.length, want.found, want.fpos, want.status);
            $display("%t: result %0d got val %h len %0d fnd %b pos %0d st %0d",
                     $realtime, checked_cnt,
                     got.value, got.length, got.found, got.fpos, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("ordered_byte_list_engine_top regression: fail");
      $finish;
    end
  end

endmodule
